@@ hdl/write_ahead_log_tracker_unit_defines.svh @@
// assertion macros for the write-ahead log tracker
`ifndef WRITE_AHEAD_LOG_TRACKER_UNIT_DEFINES_SVH
`define WRITE_AHEAD_LOG_TRACKER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define WAL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WAL_ASSERT(lbl, clk, rst, prop, msg)
`define WAL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/walt_pkg.sv @@
// types, constants and the control program of the write-ahead log tracker
package walt_pkg;

   localparam int LOG_SLOTS_DEF     = 16;
   localparam int BLOCKS_PER_OP_DEF = 4;

   localparam int CNT_W  = 5;
   localparam int NEED_W = 10;

   localparam logic [31:0] LOG_START_RST  = 32'd2;
   localparam logic [12:0] LOG_BLOCKS_RST = 13'd17;

   localparam logic [1:0] CSR_LOG_START  = 2'd0;
   localparam logic [1:0] CSR_LOG_BLOCKS = 2'd1;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_END   = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ACT_GRANTED    = 4'd0,
      ACT_WAIT       = 4'd1,
      ACT_RECORDED   = 4'd2,
      ACT_ABSORBED   = 4'd3,
      ACT_TOO_LARGE  = 4'd4,
      ACT_OUTSIDE    = 4'd5,
      ACT_UNMATCHED  = 4'd6,
      ACT_END_ACK    = 4'd7,
      ACT_COPY       = 4'd8,
      ACT_HDR_ENTRY  = 4'd9,
      ACT_HDR_WRITE  = 4'd10,
      ACT_INSTALL    = 4'd11,
      ACT_HDR_CLEAR  = 4'd12
   } action_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_CMD_WRITE,
      COND_CMD_END,
      COND_CMD_NONE,
      COND_BEGIN_FULL,
      COND_TOO_LARGE,
      COND_NO_OPEN,
      COND_IDX_END,
      COND_MATCH,
      COND_COMMIT_DUE
   } cond_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISP_WRITE, ST_DISP_END, ST_DISP_NONE,
      ST_B_CHECK, ST_B_GRANT, ST_B_WAIT,
      ST_W_LARGE_CHK, ST_W_OPEN_CHK, ST_W_SCAN, ST_W_CMP, ST_W_NEXT,
      ST_W_RECORD, ST_W_ABSORB, ST_W_LARGE, ST_W_OUTSIDE,
      ST_E_CHECK, ST_E_CLOSE, ST_E_ACK, ST_E_UNMATCHED,
      ST_C_COPY_CHK, ST_C_COPY, ST_C_HDR_INIT, ST_C_HDR_CHK, ST_C_HDR,
      ST_C_HDR_WRITE, ST_C_INST_CHK, ST_C_INST, ST_C_CLEAR
   } step_type;

   typedef enum logic [1:0] {SRC_ZERO, SRC_BLK, SRC_RDATA, SRC_SLOT_ADDR} src_sel_type;
   typedef enum logic [1:0] {TGT_ZERO, TGT_START, TGT_SLOT_ADDR, TGT_RDATA} tgt_sel_type;
   typedef enum logic [1:0] {SLOT_ZERO, SLOT_IDX, SLOT_COUNT} slot_sel_type;
   typedef enum logic [1:0] {IDX_HOLD, IDX_CLEAR, IDX_INC} idx_op_type;
   typedef enum logic [1:0] {OPEN_HOLD, OPEN_INC, OPEN_DEC} open_op_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_CLEAR} cnt_op_type;

   typedef struct packed {
      logic         take;
      cond_type     cond;
      step_type     target;
      logic         emit;
      action_type   act;
      src_sel_type  src;
      tgt_sel_type  tgt;
      slot_sel_type slot;
      logic         last;
      idx_op_type   idx_op;
      open_op_type  open_op;
      cnt_op_type   cnt_op;
      logic         mem_we;
   } ctrl_type;

   typedef struct packed {
      logic no_req;
      logic cmd_write;
      logic cmd_end;
      logic cmd_none;
      logic begin_full;
      logic too_large;
      logic no_open;
      logic idx_end;
      logic match;
      logic commit_due;
   } flags_type;

   // control store: one word per step, jump taken when cond holds, else next step
   function automatic ctrl_type ucode_rd(input step_type pc);
      ctrl_type cw;
      cw = '0;
      case (pc)
         ST_IDLE: begin
            cw.take = 1'b1; cw.idx_op = IDX_CLEAR;
            cw.cond = COND_NO_REQ; cw.target = ST_IDLE;
         end
         ST_DISP_WRITE: begin
            cw.cond = COND_CMD_WRITE; cw.target = ST_W_LARGE_CHK;
         end
         ST_DISP_END: begin
            cw.cond = COND_CMD_END; cw.target = ST_E_CHECK;
         end
         ST_DISP_NONE: begin
            cw.cond = COND_CMD_NONE; cw.target = ST_IDLE;
         end
         ST_B_CHECK: begin
            cw.cond = COND_BEGIN_FULL; cw.target = ST_B_WAIT;
         end
         ST_B_GRANT: begin
            cw.emit = 1'b1; cw.act = ACT_GRANTED; cw.last = 1'b1;
            cw.open_op = OPEN_INC; cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
         ST_B_WAIT: begin
            cw.emit = 1'b1; cw.act = ACT_WAIT; cw.last = 1'b1;
            cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
         ST_W_LARGE_CHK: begin
            cw.cond = COND_TOO_LARGE; cw.target = ST_W_LARGE;
         end
         ST_W_OPEN_CHK: begin
            cw.cond = COND_NO_OPEN; cw.target = ST_W_OUTSIDE;
         end
         ST_W_SCAN: begin
            cw.cond = COND_IDX_END; cw.target = ST_W_RECORD;
         end
         ST_W_CMP: begin
            cw.cond = COND_MATCH; cw.target = ST_W_ABSORB;
         end
         ST_W_NEXT: begin
            cw.idx_op = IDX_INC; cw.cond = COND_ALWAYS; cw.target = ST_W_SCAN;
         end
         ST_W_RECORD: begin
            cw.emit = 1'b1; cw.act = ACT_RECORDED; cw.src = SRC_BLK;
            cw.slot = SLOT_IDX; cw.last = 1'b1; cw.mem_we = 1'b1;
            cw.cnt_op = CNT_INC; cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
         ST_W_ABSORB: begin
            cw.emit = 1'b1; cw.act = ACT_ABSORBED; cw.src = SRC_BLK;
            cw.slot = SLOT_IDX; cw.last = 1'b1;
            cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
         ST_W_LARGE: begin
            cw.emit = 1'b1; cw.act = ACT_TOO_LARGE; cw.last = 1'b1;
            cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
         ST_W_OUTSIDE: begin
            cw.emit = 1'b1; cw.act = ACT_OUTSIDE; cw.last = 1'b1;
            cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
         ST_E_CHECK: begin
            cw.cond = COND_NO_OPEN; cw.target = ST_E_UNMATCHED;
         end
         ST_E_CLOSE: begin
            cw.open_op = OPEN_DEC; cw.cond = COND_COMMIT_DUE; cw.target = ST_C_COPY_CHK;
         end
         ST_E_ACK: begin
            cw.emit = 1'b1; cw.act = ACT_END_ACK; cw.last = 1'b1;
            cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
         ST_E_UNMATCHED: begin
            cw.emit = 1'b1; cw.act = ACT_UNMATCHED; cw.last = 1'b1;
            cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
         ST_C_COPY_CHK: begin
            cw.cond = COND_IDX_END; cw.target = ST_C_HDR_INIT;
         end
         ST_C_COPY: begin
            cw.emit = 1'b1; cw.act = ACT_COPY; cw.src = SRC_RDATA;
            cw.tgt = TGT_SLOT_ADDR; cw.slot = SLOT_IDX; cw.idx_op = IDX_INC;
            cw.cond = COND_ALWAYS; cw.target = ST_C_COPY_CHK;
         end
         ST_C_HDR_INIT: begin
            cw.idx_op = IDX_CLEAR;
         end
         ST_C_HDR_CHK: begin
            cw.cond = COND_IDX_END; cw.target = ST_C_HDR_WRITE;
         end
         ST_C_HDR: begin
            cw.emit = 1'b1; cw.act = ACT_HDR_ENTRY; cw.src = SRC_RDATA;
            cw.tgt = TGT_START; cw.slot = SLOT_IDX; cw.idx_op = IDX_INC;
            cw.cond = COND_ALWAYS; cw.target = ST_C_HDR_CHK;
         end
         ST_C_HDR_WRITE: begin
            cw.emit = 1'b1; cw.act = ACT_HDR_WRITE; cw.tgt = TGT_START;
            cw.slot = SLOT_COUNT; cw.idx_op = IDX_CLEAR;
         end
         ST_C_INST_CHK: begin
            cw.cond = COND_IDX_END; cw.target = ST_C_CLEAR;
         end
         ST_C_INST: begin
            cw.emit = 1'b1; cw.act = ACT_INSTALL; cw.src = SRC_SLOT_ADDR;
            cw.tgt = TGT_RDATA; cw.slot = SLOT_IDX; cw.idx_op = IDX_INC;
            cw.cond = COND_ALWAYS; cw.target = ST_C_INST_CHK;
         end
         ST_C_CLEAR: begin
            cw.emit = 1'b1; cw.act = ACT_HDR_CLEAR; cw.tgt = TGT_START;
            cw.last = 1'b1; cw.cnt_op = CNT_CLEAR;
            cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
         default: begin
            cw.cond = COND_ALWAYS; cw.target = ST_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

@@ hdl/walt_seq.sv @@
// step counter, control store and jump logic of the log tracker
module walt_seq
   import walt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   input  logic      stall,
   output ctrl_type  cw
);

   step_type pc_ff;
   step_type pc_in;
   logic     hit;

   assign cw = ucode_rd(pc_ff);

   always_comb begin
      case (cw.cond)
         COND_NEVER:      hit = 1'b0;
         COND_ALWAYS:     hit = 1'b1;
         COND_NO_REQ:     hit = flags.no_req;
         COND_CMD_WRITE:  hit = flags.cmd_write;
         COND_CMD_END:    hit = flags.cmd_end;
         COND_CMD_NONE:   hit = flags.cmd_none;
         COND_BEGIN_FULL: hit = flags.begin_full;
         COND_TOO_LARGE:  hit = flags.too_large;
         COND_NO_OPEN:    hit = flags.no_open;
         COND_IDX_END:    hit = flags.idx_end;
         COND_MATCH:      hit = flags.match;
         COND_COMMIT_DUE: hit = flags.commit_due;
         default:         hit = 1'b0;
      endcase
      if (stall) begin
         pc_in = pc_ff;
      end else if (hit) begin
         pc_in = cw.target;
      end else begin
         pc_in = step_type'(5'(pc_ff) + 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ hdl/write_ahead_log_tracker_unit.sv @@
// write-ahead log tracker: begin/write/end commands with group commit
//
// channel   dir  handshake            payload
// req_      in   req_valid/req_ready  req_cmd, req_block_number
// rsp_      out  rsp_valid/rsp_ready  action, source/target block, slot, last
// csr_      in   csr_write_enable     csr_index, csr_wdata
//
// one step per cycle unless stalled; items are taken one at a time in the idle step
// begin: dispatch, capacity check, grant or wait; end: check, close, ack or commit
// write: size and open checks, then a scan of the log slots, recorded or absorbed
// commit: copy, header and install passes, a check step and an emit step per result
// a result waiting in the output register stalls only a step that emits
// synchronous reset; the log memory needs no clearing
`include "write_ahead_log_tracker_unit_defines.svh"
module write_ahead_log_tracker_unit
   import walt_pkg::*;
#(
   parameter int LOG_SLOTS     = LOG_SLOTS_DEF,
   parameter int BLOCKS_PER_OP = BLOCKS_PER_OP_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_block_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_action,
   output logic [31:0] rsp_source_block,
   output logic [31:0] rsp_target_block,
   output logic [4:0]  rsp_slot_or_count,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = $clog2(LOG_SLOTS);

   ctrl_type    cw;
   flags_type   flags;
   logic        stall;
   logic        go;

   logic [31:0] area_start_ff;
   logic [12:0] area_blocks_ff;
   cmd_type     cmd_ff;
   logic [31:0] blk_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] open_ff, open_in;
   logic [31:0] rdata_ff;
   logic [31:0] log_mem [LOG_SLOTS];

   logic        rsp_valid_ff;
   action_type  rsp_action_ff;
   logic [31:0] rsp_src_ff;
   logic [31:0] rsp_tgt_ff;
   logic [CNT_W-1:0] rsp_slot_ff;
   logic        rsp_last_ff;

   logic [NEED_W-1:0] need;
   logic [31:0] slot_addr;
   logic [31:0] src_val;
   logic [31:0] tgt_val;
   logic [CNT_W-1:0] slot_val;

   walt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .stall (stall),
      .cw    (cw)
   );

   assign stall     = cw.emit && rsp_valid_ff && !rsp_ready;
   assign go        = !stall;
   assign req_ready = cw.take;

   assign need = NEED_W'(count_ff)
               + (NEED_W'(open_ff) + NEED_W'(1)) * NEED_W'(BLOCKS_PER_OP);
   assign slot_addr = area_start_ff + 32'(idx_ff) + 32'd1;

   always_comb begin
      flags.no_req     = !req_valid;
      flags.cmd_write  = (cmd_ff == CMD_WRITE);
      flags.cmd_end    = (cmd_ff == CMD_END);
      flags.cmd_none   = (cmd_ff == CMD_NONE);
      flags.begin_full = (need > NEED_W'(LOG_SLOTS));
      flags.too_large  = (count_ff >= CNT_W'(LOG_SLOTS))
                      || ((13'(count_ff) + 13'd1) >= area_blocks_ff);
      flags.no_open    = (open_ff == '0);
      flags.idx_end    = (idx_ff == count_ff);
      flags.match      = (rdata_ff == blk_ff);
      // closing the last open operation with a non-empty log
      flags.commit_due = (open_ff == CNT_W'(1)) && (count_ff != '0);
   end

   always_comb begin
      case (cw.src)
         SRC_BLK:       src_val = blk_ff;
         SRC_RDATA:     src_val = rdata_ff;
         SRC_SLOT_ADDR: src_val = slot_addr;
         default:       src_val = '0;
      endcase
      case (cw.tgt)
         TGT_START:     tgt_val = area_start_ff;
         TGT_SLOT_ADDR: tgt_val = slot_addr;
         TGT_RDATA:     tgt_val = rdata_ff;
         default:       tgt_val = '0;
      endcase
      case (cw.slot)
         SLOT_IDX:   slot_val = idx_ff;
         SLOT_COUNT: slot_val = count_ff;
         default:    slot_val = '0;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      open_in  = open_ff;
      if (go) begin
         case (cw.idx_op)
            IDX_CLEAR: idx_in = '0;
            IDX_INC:   idx_in = idx_ff + CNT_W'(1);
            default:   idx_in = idx_ff;
         endcase
         case (cw.cnt_op)
            CNT_INC:   count_in = count_ff + CNT_W'(1);
            CNT_CLEAR: count_in = '0;
            default:   count_in = count_ff;
         endcase
         case (cw.open_op)
            OPEN_INC: open_in = open_ff + CNT_W'(1);
            OPEN_DEC: open_in = open_ff - CNT_W'(1);
            default:  open_in = open_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_start_ff  <= LOG_START_RST;
         area_blocks_ff <= LOG_BLOCKS_RST;
         count_ff       <= '0;
         open_ff        <= '0;
         idx_ff         <= '0;
         cmd_ff         <= CMD_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LOG_START:  area_start_ff  <= csr_wdata;
               CSR_LOG_BLOCKS: area_blocks_ff <= csr_wdata[12:0];
               default: ;
            endcase
         end
         count_ff <= count_in;
         open_ff  <= open_in;
         idx_ff   <= idx_in;
         if (req_valid && req_ready) begin
            cmd_ff <= cmd_type'(req_cmd);
         end
         if (go && cw.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         blk_ff <= req_block_number;
      end
      if (go && cw.emit) begin
         rsp_action_ff <= cw.act;
         rsp_src_ff    <= src_val;
         rsp_tgt_ff    <= tgt_val;
         rsp_slot_ff   <= slot_val;
         rsp_last_ff   <= cw.last;
      end
   end

   // log slot store, one write per unstalled cycle and one registered read per cycle
   always_ff @(posedge clock) begin
      if (go && cw.mem_we) begin
         log_mem[idx_ff[IDX_W-1:0]] <= blk_ff;
      end
      rdata_ff <= log_mem[idx_ff[IDX_W-1:0]];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_source_block  = rsp_src_ff;
   assign rsp_target_block  = rsp_tgt_ff;
   assign rsp_slot_or_count = rsp_slot_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   `WAL_ASSERT(a_count_fits, clock, reset, count_ff <= CNT_W'(LOG_SLOTS), "log count overflow")
   `WAL_ASSERT(a_open_bound, clock, reset, 32'(open_ff) * BLOCKS_PER_OP <= LOG_SLOTS, "too many open")
   `WAL_ASSERT(a_idx_in_range, clock, reset, !cw.take |-> idx_ff <= count_ff, "slot index past count")
   `WAL_ASSERT(a_leave_idle, clock, reset, (req_valid && req_ready) |=> !req_ready, "stayed idle")

endmodule
